FILE: rtl/core/prsm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prsm_pkg
// Types and constants shared by the pulse-rate speed meter modules.
// ----------------------------------------------------------------------------
package prsm_pkg;

    // item operation codes
    localparam logic OP_PULSE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    // register map, index = paddr[3:2]
    localparam int  ADDR_W  = 4;
    localparam int  IDX_W   = 2;
    localparam logic [IDX_W-1:0] REG_ENABLED = 2'd0;
    localparam logic [IDX_W-1:0] REG_PPM     = 2'd1;
    localparam logic [IDX_W-1:0] REG_TIMEOUT = 2'd2;
    localparam logic [IDX_W-1:0] REG_UNITS   = 2'd3;

    localparam logic [15:0] PPM_RESET     = 16'd4000;
    localparam logic [31:0] TIMEOUT_RESET = 32'd1000;

    // field widths
    localparam int SPEED_W = 24;
    localparam int WORD_W  = 32;
    localparam int PPM_W   = 16;

    localparam logic [SPEED_W-1:0] SPEED_MAX = {SPEED_W{1'b1}};

    // 3600 s * 1e6 us, and the same times 1.60934 for km/h
    localparam logic [32:0] K_MPH = 33'd3600000000;
    localparam logic [32:0] K_KPH = 33'd5793624000;

    // us to ms: floor(x / 1000) = (x * ceil(2^38 / 1000)) >> 38 for any 32-bit x
    localparam logic [WORD_W-1:0] MS_RECIP = 32'd274877907;
    localparam int                MS_SHIFT = 38;

    // divider
    localparam int DIV_W = 48;
    localparam int DVD_W = 32;
    localparam int CNT_W = 6;
    localparam logic [CNT_W-1:0] STEPS_SPEED = 6'd24;

    typedef struct packed {
        logic             enabled;
        logic [PPM_W-1:0] ppm;
        logic [WORD_W-1:0] timeout_ms;
        logic             units_kph;
        logic             clear;
    } prsm_cfg_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] rem;
        logic [DVD_W-1:0] dvd;
        logic [DIV_W-1:0] dvs;
        logic [CNT_W-1:0] steps;
    } div_cmd_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DVD_W-1:0] quo;
    } div_stat_t;

    typedef enum logic [8:0] {
        S_IDLE    = 9'b0_0000_0001,
        S_EVAL    = 9'b0_0000_0010,
        S_MUL1    = 9'b0_0000_0100,
        S_MUL2    = 9'b0_0000_1000,
        S_CMP     = 9'b0_0001_0000,
        S_MS_MUL  = 9'b0_0010_0000,
        S_MS_CMP  = 9'b0_0100_0000,
        S_DIV_SPD = 9'b0_1000_0000,
        S_OUT     = 9'b1_0000_0000
    } state_t;

endpackage

FILE: rtl/core/prsm_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prsm_in_if / prsm_out_if
// Valid/ready channels of the speed meter: event items in, readings out.
// ----------------------------------------------------------------------------
interface prsm_in_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [31:0] now_us;

    modport source (output valid, op, now_us, input ready);
    modport sink   (input valid, op, now_us, output ready);
endinterface

interface prsm_out_if;
    logic        valid;
    logic        ready;
    logic [23:0] speed;
    logic [31:0] pulse_count;
    logic [31:0] accumulated_pulses;
    logic [31:0] ms_since_pulse;
    logic        stopped;

    modport source (output valid, speed, pulse_count, accumulated_pulses, ms_since_pulse,
                    stopped, input ready);
    modport sink   (input valid, speed, pulse_count, accumulated_pulses, ms_since_pulse,
                    stopped, output ready);
endinterface

FILE: rtl/core/prsm_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prsm_cfg
// APB register file: enable, pulses per mile, stop timeout, units.
// ----------------------------------------------------------------------------
module prsm_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [prsm_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output prsm_pkg::prsm_cfg_t         cfg
);

    logic                       enabled_reg;
    logic                       enabled_next;
    logic [prsm_pkg::PPM_W-1:0] ppm_reg;
    logic [prsm_pkg::PPM_W-1:0] ppm_next;
    logic [31:0]                timeout_reg;
    logic [31:0]                timeout_next;
    logic                       units_reg;
    logic                       units_next;
    logic                       wr;
    logic [prsm_pkg::IDX_W-1:0] idx;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign idx    = paddr[prsm_pkg::ADDR_W-1:2];

    always_comb
    begin
        enabled_next = enabled_reg;
        ppm_next     = ppm_reg;
        timeout_next = timeout_reg;
        units_next   = units_reg;
        if (wr)
        begin
            unique case (idx)
                prsm_pkg::REG_ENABLED: enabled_next = pwdata[0];
                prsm_pkg::REG_PPM:     ppm_next     = pwdata[prsm_pkg::PPM_W-1:0];
                prsm_pkg::REG_TIMEOUT: timeout_next = pwdata;
                prsm_pkg::REG_UNITS:   units_next   = pwdata[0];
                default:               ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg <= 1'b0;
            ppm_reg     <= prsm_pkg::PPM_RESET;
            timeout_reg <= prsm_pkg::TIMEOUT_RESET;
            units_reg   <= 1'b0;
        end
        else
        begin
            enabled_reg <= enabled_next;
            ppm_reg     <= ppm_next;
            timeout_reg <= timeout_next;
            units_reg   <= units_next;
        end
    end

    always_comb
    begin
        unique case (idx)
            prsm_pkg::REG_ENABLED: prdata = {31'b0, enabled_reg};
            prsm_pkg::REG_PPM:     prdata = {16'b0, ppm_reg};
            prsm_pkg::REG_TIMEOUT: prdata = timeout_reg;
            prsm_pkg::REG_UNITS:   prdata = {31'b0, units_reg};
            default:               prdata = 32'b0;
        endcase
    end

    // enabling from off restarts the measurement
    always_comb
    begin
        cfg.enabled    = enabled_reg;
        cfg.ppm        = ppm_reg;
        cfg.timeout_ms = timeout_reg;
        cfg.units_kph  = units_reg;
        cfg.clear      = wr && (idx == prsm_pkg::REG_ENABLED) && pwdata[0] && !enabled_reg;
    end

endmodule

FILE: rtl/core/prsm_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prsm_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module prsm_div (
    input  logic                clk,
    input  logic                rst_n,
    input  prsm_pkg::div_cmd_t  cmd,
    output prsm_pkg::div_stat_t stat
);

    localparam int DIV_W = prsm_pkg::DIV_W;
    localparam int DVD_W = prsm_pkg::DVD_W;
    localparam int CNT_W = prsm_pkg::CNT_W;

    logic             busy_reg;
    logic             busy_next;
    logic             done_reg;
    logic             done_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [DIV_W-1:0] rem_reg;
    logic [DIV_W-1:0] rem_next;
    logic [DVD_W-1:0] dvd_reg;
    logic [DVD_W-1:0] dvd_next;
    logic [DIV_W-1:0] dvs_reg;
    logic [DIV_W-1:0] dvs_next;
    logic [DVD_W-1:0] quo_reg;
    logic [DVD_W-1:0] quo_next;
    logic [DIV_W:0]   trial;
    logic [DIV_W:0]   diff;
    logic             ge;

    // remainder stays below the divisor, so the shifted trial fits DIV_W+1 bits
    assign trial = {rem_reg, dvd_reg[DVD_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign ge    = trial >= {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        if (cmd.start)
        begin
            busy_next = 1'b1;
            cnt_next  = cmd.steps;
            rem_next  = cmd.rem;
            dvd_next  = cmd.dvd;
            dvs_next  = cmd.dvs;
            quo_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
            dvd_next = {dvd_reg[DVD_W-2:0], 1'b0};
            quo_next = {quo_reg[DVD_W-2:0], ge};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    always_comb
    begin
        stat.busy = busy_reg;
        stat.done = done_reg;
        stat.quo  = quo_reg;
    end

endmodule

FILE: rtl/core/pulse_rate_speed_meter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pulse_rate_speed_meter_unit
// Pulse counter and speed reading sequencer around one divider.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake       | payload
//  in_ch    | in  | valid / ready   | op, now_us
//  out_ch   | out | valid / ready   | speed, pulse_count, accumulated_pulses,
//           |     |                 | ms_since_pulse, stopped
//  APB      | in  | psel / penable  | paddr, pwdata, prdata (pready always high)
//
// A pulse item is handled in S_IDLE without leaving it. A read goes from
// S_EVAL straight to S_OUT when disabled, on a baseline or with nothing to
// time; a speed takes two multiplier passes, a saturation compare and 24
// divider steps, and the ms age alone takes one reciprocal multiply and
// the timeout compare.
// in_ch.ready is low from a read's acceptance until its result is taken.
// Reset clears all counters and stamps; no clearing pass is needed.
// ----------------------------------------------------------------------------
module pulse_rate_speed_meter_unit #(
    parameter int SPEED_FRAC_BITS = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [prsm_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    prsm_in_if.sink                     in_ch,
    prsm_out_if.source                  out_ch
);

    localparam int W     = prsm_pkg::WORD_W;
    localparam int SW    = prsm_pkg::SPEED_W;
    localparam int DIV_W = prsm_pkg::DIV_W;
    localparam int N_W   = 65 + SPEED_FRAC_BITS;
    localparam int HI_W  = N_W - SW;
    localparam int CMP_W = (HI_W > DIV_W) ? HI_W : DIV_W;

    prsm_pkg::prsm_cfg_t cfg;
    prsm_pkg::div_cmd_t  div_cmd;
    prsm_pkg::div_stat_t div_stat;

    prsm_pkg::state_t state_reg;
    prsm_pkg::state_t state_next;

    // measurement state
    logic [W-1:0]  pulse_total_reg;
    logic [W-1:0]  pulse_total_next;
    logic [W-1:0]  last_total_reg;
    logic [W-1:0]  last_total_next;
    logic [W-1:0]  last_read_reg;
    logic [W-1:0]  last_read_next;
    logic          baseline_reg;
    logic          baseline_next;
    logic [W-1:0]  last_pulse_reg;
    logic [W-1:0]  last_pulse_next;
    logic          pulse_seen_reg;
    logic          pulse_seen_next;
    logic [W-1:0]  delta_sum_reg;
    logic [W-1:0]  delta_sum_next;

    // working registers
    logic [W-1:0]     now_reg;
    logic [W-1:0]     now_next;
    logic [W-1:0]     delta_reg;
    logic [W-1:0]     delta_next;
    logic [W-1:0]     elapsed_reg;
    logic [W-1:0]     elapsed_next;
    logic [63:0]      prod_reg;
    logic [63:0]      prod_next;
    logic [N_W-1:0]   num_reg;
    logic [N_W-1:0]   num_next;
    logic             chk_stop_reg;
    logic             chk_stop_next;

    // result registers
    logic [SW-1:0]    speed_reg;
    logic [SW-1:0]    speed_next;
    logic [W-1:0]     count_reg;
    logic [W-1:0]     count_next;
    logic [W-1:0]     since_reg;
    logic [W-1:0]     since_next;
    logic             stop_reg;
    logic             stop_next;

    logic             accept;
    logic [W-1:0]     delta_c;
    logic [W-1:0]     elapsed_c;
    logic             stamp;
    logic [32:0]      k_sel;
    logic [W-1:0]     mul_a;
    logic [W-1:0]     mul_b;
    logic [63:0]      mul_p;
    logic [64:0]      num_sum;
    logic [CMP_W-1:0] num_hi;
    logic [CMP_W-1:0] den_ext;
    logic             ovf;
    logic [W-1:0]     ms_age;

    prsm_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    prsm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (div_cmd),
        .stat  (div_stat)
    );

    assign in_ch.ready = (state_reg == prsm_pkg::S_IDLE);
    assign accept      = in_ch.valid && in_ch.ready;

    assign delta_c   = pulse_total_reg - last_total_reg;
    assign elapsed_c = now_reg - last_read_reg;
    assign stamp     = baseline_reg && (delta_c != '0);
    assign k_sel     = cfg.units_kph ? prsm_pkg::K_KPH : prsm_pkg::K_MPH;

    // one 32x32 multiplier: delta * K[31:0] first, then elapsed * ppm;
    // the ms age goes through it once, times the reciprocal of 1000
    always_comb
    begin
        mul_a = elapsed_reg;
        mul_b = {{(W-prsm_pkg::PPM_W){1'b0}}, cfg.ppm};
        if (state_reg == prsm_pkg::S_MUL1)
        begin
            mul_a = delta_reg;
            mul_b = k_sel[W-1:0];
        end
        else if (state_reg == prsm_pkg::S_MS_MUL)
        begin
            mul_a = delta_reg;
            mul_b = prsm_pkg::MS_RECIP;
        end
    end

    assign mul_p = 64'(mul_a) * 64'(mul_b);

    assign ms_age = W'(prod_reg[63:prsm_pkg::MS_SHIFT]);

    assign num_sum = {1'b0, prod_reg} + (k_sel[32] ? {1'b0, delta_reg, 32'b0} : 65'b0);

    // quotient fits 24 bits only if the numerator's top part is below the divisor
    assign num_hi  = CMP_W'(num_reg[N_W-1:SW]);
    assign den_ext = CMP_W'(prod_reg[DIV_W-1:0]);
    assign ovf     = num_hi >= den_ext;

    always_comb
    begin
        state_next       = state_reg;
        pulse_total_next = pulse_total_reg;
        last_total_next  = last_total_reg;
        last_read_next   = last_read_reg;
        baseline_next    = baseline_reg;
        last_pulse_next  = last_pulse_reg;
        pulse_seen_next  = pulse_seen_reg;
        delta_sum_next   = delta_sum_reg;
        now_next         = now_reg;
        delta_next       = delta_reg;
        elapsed_next     = elapsed_reg;
        prod_next        = prod_reg;
        num_next         = num_reg;
        chk_stop_next    = chk_stop_reg;
        speed_next       = speed_reg;
        count_next       = count_reg;
        since_next       = since_reg;
        stop_next        = stop_reg;
        div_cmd.start    = 1'b0;
        div_cmd.rem      = '0;
        div_cmd.dvd      = '0;
        div_cmd.dvs      = '0;
        div_cmd.steps    = prsm_pkg::STEPS_SPEED;

        unique case (state_reg)
            prsm_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    if (in_ch.op == prsm_pkg::OP_READ)
                    begin
                        now_next   = in_ch.now_us;
                        state_next = prsm_pkg::S_EVAL;
                    end
                    else if (cfg.enabled)
                    begin
                        pulse_total_next = pulse_total_reg + W'(1);
                    end
                end
            end

            prsm_pkg::S_EVAL:
            begin
                speed_next = '0;
                stop_next  = 1'b0;
                state_next = prsm_pkg::S_OUT;
                if (!cfg.enabled)
                begin
                    count_next = '0;
                    since_next = '1;
                end
                else
                begin
                    count_next      = pulse_total_reg;
                    last_total_next = pulse_total_reg;
                    last_read_next  = now_reg;
                    baseline_next   = 1'b1;
                    delta_next      = delta_c;
                    elapsed_next    = elapsed_c;
                    chk_stop_next   = baseline_reg;
                    if (stamp)
                    begin
                        last_pulse_next = now_reg;
                        pulse_seen_next = 1'b1;
                        delta_sum_next  = delta_sum_reg + delta_c;
                        since_next      = '0;
                        if (elapsed_c != '0)
                        begin
                            state_next = prsm_pkg::S_MUL1;
                        end
                    end
                    else if (pulse_seen_reg)
                    begin
                        // age of the last stamp in us, scaled to ms next
                        delta_next = now_reg - last_pulse_reg;
                        state_next = prsm_pkg::S_MS_MUL;
                    end
                    else
                    begin
                        since_next = '1;
                    end
                end
            end

            prsm_pkg::S_MUL1:
            begin
                prod_next  = mul_p;
                state_next = prsm_pkg::S_MUL2;
            end

            prsm_pkg::S_MUL2:
            begin
                num_next   = N_W'(num_sum) << SPEED_FRAC_BITS;
                prod_next  = mul_p;
                state_next = prsm_pkg::S_CMP;
            end

            prsm_pkg::S_CMP:
            begin
                if (ovf)
                begin
                    speed_next = prsm_pkg::SPEED_MAX;
                    state_next = prsm_pkg::S_OUT;
                end
                else
                begin
                    div_cmd.start = 1'b1;
                    div_cmd.rem   = num_hi[DIV_W-1:0];
                    div_cmd.dvd   = {num_reg[SW-1:0], {(prsm_pkg::DVD_W-SW){1'b0}}};
                    div_cmd.dvs   = prod_reg[DIV_W-1:0];
                    div_cmd.steps = prsm_pkg::STEPS_SPEED;
                    state_next    = prsm_pkg::S_DIV_SPD;
                end
            end

            prsm_pkg::S_MS_MUL:
            begin
                prod_next  = mul_p;
                state_next = prsm_pkg::S_MS_CMP;
            end

            prsm_pkg::S_MS_CMP:
            begin
                since_next = ms_age;
                stop_next  = chk_stop_reg && (ms_age > cfg.timeout_ms);
                state_next = prsm_pkg::S_OUT;
            end

            prsm_pkg::S_DIV_SPD:
            begin
                if (div_stat.done)
                begin
                    speed_next = div_stat.quo[SW-1:0];
                    state_next = prsm_pkg::S_OUT;
                end
            end

            prsm_pkg::S_OUT:
            begin
                if (out_ch.ready)
                begin
                    state_next = prsm_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = prsm_pkg::S_IDLE;
            end
        endcase

        if (cfg.clear)
        begin
            pulse_total_next = '0;
            last_total_next  = '0;
            last_read_next   = '0;
            baseline_next    = 1'b0;
            last_pulse_next  = '0;
            pulse_seen_next  = 1'b0;
            delta_sum_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= prsm_pkg::S_IDLE;
            pulse_total_reg <= '0;
            last_total_reg  <= '0;
            last_read_reg   <= '0;
            baseline_reg    <= 1'b0;
            last_pulse_reg  <= '0;
            pulse_seen_reg  <= 1'b0;
            delta_sum_reg   <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            pulse_total_reg <= pulse_total_next;
            last_total_reg  <= last_total_next;
            last_read_reg   <= last_read_next;
            baseline_reg    <= baseline_next;
            last_pulse_reg  <= last_pulse_next;
            pulse_seen_reg  <= pulse_seen_next;
            delta_sum_reg   <= delta_sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg      <= now_next;
        delta_reg    <= delta_next;
        elapsed_reg  <= elapsed_next;
        prod_reg     <= prod_next;
        num_reg      <= num_next;
        chk_stop_reg <= chk_stop_next;
        speed_reg    <= speed_next;
        count_reg    <= count_next;
        since_reg    <= since_next;
        stop_reg     <= stop_next;
    end

    assign out_ch.valid              = (state_reg == prsm_pkg::S_OUT);
    assign out_ch.speed              = speed_reg;
    assign out_ch.pulse_count        = count_reg;
    assign out_ch.accumulated_pulses = delta_sum_reg;
    assign out_ch.ms_since_pulse     = since_reg;
    assign out_ch.stopped            = stop_reg;

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the pulse-rate speed meter. A table of directed
// pulses, reads and register writes runs first, then randomised phases of
// pulse bursts and timed reads under fresh register settings. Each reading
// is compared field by field with the table's value or a model of the meter.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int          SPEED_FRAC   = 8;
    localparam logic [63:0] MPH_SCALE    = 64'd3600000000;
    localparam logic [63:0] KPH_SCALE    = 64'd5793624000;
    localparam logic [23:0] SPEED_SAT    = 24'hFF_FFFF;
    localparam logic [31:0] US_IN_MS     = 32'd1000;
    localparam int          SETTLE_CYC   = 48;
    localparam int          N_PHASES     = 12;
    localparam int          PHASE_ITEMS  = 100;
    localparam int          HOLD_CYC     = 300;

    typedef struct packed {
        logic [23:0] speed;
        logic [31:0] pulse_count;
        logic [31:0] accumulated;
        logic [31:0] age_ms;
        logic        stopped;
    } reading_t;

    typedef enum logic { ROW_REG, ROW_ITEM } row_kind_t;

    typedef struct {
        row_kind_t                  kind;
        logic [prsm_pkg::IDX_W-1:0] reg_idx;
        logic [31:0]                value;
        logic                       op;
        logic [31:0]                now;
        bit                         typed;
        reading_t                   want;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n;

    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [prsm_pkg::ADDR_W-1:0] paddr;
    logic [31:0]                 pwdata;
    logic [31:0]                 prdata;
    logic                        pready;

    prsm_in_if  in_if ();
    prsm_out_if out_if ();

    pulse_rate_speed_meter_unit #(
        .SPEED_FRAC_BITS (SPEED_FRAC)
    ) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_if),
        .out_ch  (out_if)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // meter model: register copy and counters
    // ------------------------------------------------------------------
    logic        cfg_enabled;
    logic [15:0] cfg_ppm;
    logic [31:0] cfg_timeout_ms;
    logic        cfg_kph;

    logic [31:0] cnt_total;
    logic [31:0] cnt_at_read;
    logic [31:0] read_stamp;
    logic        have_baseline;
    logic [31:0] pulse_stamp;
    logic        pulse_stamped;
    logic [31:0] delta_total;

    reading_t    pending_readings[$];
    stim_row_t   directed_rows[$];

    int unsigned n_err     = 0;
    int unsigned n_checked = 0;
    bit          idle_on   = 1'b1;

    function automatic void meter_clear();
        cnt_total     = '0;
        cnt_at_read   = '0;
        read_stamp    = '0;
        have_baseline = 1'b0;
        pulse_stamp   = '0;
        pulse_stamped = 1'b0;
        delta_total   = '0;
    endfunction

    function automatic void meter_write_reg(input logic [prsm_pkg::IDX_W-1:0] idx,
                                            input logic [31:0] val);
        case (idx)
            prsm_pkg::REG_ENABLED:
            begin
                // enabling from off restarts everything, baseline included
                if (val[0] && !cfg_enabled)
                    meter_clear();
                cfg_enabled = val[0];
            end
            prsm_pkg::REG_PPM:     cfg_ppm        = val[15:0];
            prsm_pkg::REG_TIMEOUT: cfg_timeout_ms = val;
            prsm_pkg::REG_UNITS:   cfg_kph        = val[0];
            default:               ;
        endcase
    endfunction

    // floor(delta * scale * 2^frac / (elapsed * ppm)), saturating at 24 bits
    function automatic logic [23:0] speed_q(input logic [31:0] delta,
                                            input logic [31:0] elapsed);
        logic [127:0] num;
        logic [127:0] den;
        logic [127:0] quo;
        if (delta == 0)
            return '0;
        den = {96'd0, elapsed} * {112'd0, cfg_ppm};
        if (den == 0)
            return SPEED_SAT;
        num = ({96'd0, delta} * (cfg_kph ? KPH_SCALE : MPH_SCALE)) << SPEED_FRAC;
        quo = num / den;
        return (quo > {104'd0, SPEED_SAT}) ? SPEED_SAT : quo[23:0];
    endfunction

    function automatic reading_t meter_read(input logic [31:0] now);
        reading_t    r;
        logic [31:0] delta;
        logic [31:0] elapsed;
        r = '0;
        if (!cfg_enabled)
        begin
            r.accumulated = delta_total;
            r.age_ms      = '1;
            return r;
        end
        if (!have_baseline)
        begin
            cnt_at_read   = cnt_total;
            read_stamp    = now;
            have_baseline = 1'b1;
        end
        else
        begin
            delta   = cnt_total - cnt_at_read;
            elapsed = now - read_stamp;
            if (delta != 0)
            begin
                pulse_stamp   = now;
                pulse_stamped = 1'b1;
                delta_total   = delta_total + delta;
            end
            cnt_at_read = cnt_total;
            read_stamp  = now;
            if (pulse_stamped && ((now - pulse_stamp) / US_IN_MS) > cfg_timeout_ms)
                r.stopped = 1'b1;
            else if (elapsed != 0)
                r.speed = speed_q(delta, elapsed);
        end
        r.pulse_count = cnt_total;
        r.accumulated = delta_total;
        r.age_ms      = pulse_stamped ? (now - pulse_stamp) / US_IN_MS : '1;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------
    task automatic send_item(input logic op, input logic [31:0] now,
                             input bit typed, input reading_t want);
        reading_t got;
        @(negedge clk);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
        in_if.valid  <= 1'b1;
        in_if.op     <= op;
        in_if.now_us <= now;
        do
            @(posedge clk);
        while (!in_if.ready);
        if (op == prsm_pkg::OP_READ)
        begin
            got = meter_read(now);
            pending_readings.push_back(typed ? want : got);
        end
        else if (cfg_enabled)
        begin
            cnt_total = cnt_total + 1;
        end
    endtask

    task automatic reg_write(input logic [prsm_pkg::IDX_W-1:0] idx, input logic [31:0] val);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        meter_write_reg(idx, val);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // withdraw the last item before the next edge, then wait for all readings
    task automatic wait_idle();
        @(negedge clk);
        in_if.valid <= 1'b0;
        while (pending_readings.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // directed table
    // ------------------------------------------------------------------
    function automatic stim_row_t blank_row();
        stim_row_t row;
        row.kind    = ROW_ITEM;
        row.reg_idx = '0;
        row.value   = '0;
        row.op      = prsm_pkg::OP_PULSE;
        row.now     = '0;
        row.typed   = 1'b0;
        row.want    = '0;
        return row;
    endfunction

    function automatic void add_reg(input logic [prsm_pkg::IDX_W-1:0] idx,
                                    input logic [31:0] val);
        stim_row_t row;
        row         = blank_row();
        row.kind    = ROW_REG;
        row.reg_idx = idx;
        row.value   = val;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_item(input logic op, input logic [31:0] now);
        stim_row_t row;
        row      = blank_row();
        row.kind = ROW_ITEM;
        row.op   = op;
        row.now  = now;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_read_typed(input logic [31:0] now, input logic [23:0] spd,
                                           input logic [31:0] cnt, input logic [31:0] acc,
                                           input logic [31:0] age, input logic stp);
        stim_row_t row;
        row       = blank_row();
        row.kind  = ROW_ITEM;
        row.op    = prsm_pkg::OP_READ;
        row.now   = now;
        row.typed = 1'b1;
        row.want  = '{speed: spd, pulse_count: cnt, accumulated: acc,
                      age_ms: age, stopped: stp};
        directed_rows.push_back(row);
    endfunction

    function automatic void build_directed();
        // disabled after reset
        add_read_typed(32'd0, 24'd0, 32'd0, 32'd0, 32'hFFFF_FFFF, 1'b0);
        add_item(prsm_pkg::OP_PULSE, 32'hFFFF_FFFF);
        add_read_typed(32'hFFFF_FFFF, 24'd0, 32'd0, 32'd0, 32'hFFFF_FFFF, 1'b0);
        add_reg(prsm_pkg::REG_ENABLED, 32'd1);
        // baseline, then one second of four pulses
        add_read_typed(32'd1000, 24'd0, 32'd0, 32'd0, 32'hFFFF_FFFF, 1'b0);
        repeat (4) add_item(prsm_pkg::OP_PULSE, 32'h0);
        add_item(prsm_pkg::OP_READ, 32'd1_001_000);
        // zero elapsed, then past the default 1000 ms timeout
        add_read_typed(32'd1_001_000, 24'd0, 32'd4, 32'd4, 32'd0, 1'b0);
        add_read_typed(32'd2_002_000, 24'd0, 32'd4, 32'd4, 32'd1001, 1'b1);
        // km/h, one pulse per mile, 1 us apart: saturates
        add_reg(prsm_pkg::REG_UNITS, 32'd1);
        add_reg(prsm_pkg::REG_PPM, 32'd1);
        add_reg(prsm_pkg::REG_TIMEOUT, 32'hFFFF_FFFF);
        add_item(prsm_pkg::OP_PULSE, 32'h5555_5555);
        add_read_typed(32'd2_002_001, SPEED_SAT, 32'd5, 32'd5, 32'd0, 1'b0);
        // zero divisor
        add_reg(prsm_pkg::REG_PPM, 32'd0);
        add_item(prsm_pkg::OP_PULSE, 32'hAAAA_AAAA);
        add_read_typed(32'd2_002_006, SPEED_SAT, 32'd6, 32'd6, 32'd0, 1'b0);
        add_read_typed(32'd2_002_016, 24'd0, 32'd6, 32'd6, 32'd0, 1'b0);
        // widest divisor, timestamp wrap, zero timeout
        add_reg(prsm_pkg::REG_PPM, 32'hFFFF_FFFF);
        add_reg(prsm_pkg::REG_UNITS, 32'hFFFF_FFFE);
        add_reg(prsm_pkg::REG_TIMEOUT, 32'd0);
        add_item(prsm_pkg::OP_PULSE, 32'h0);
        add_item(prsm_pkg::OP_READ, 32'hFFFF_FFF0);
        add_item(prsm_pkg::OP_PULSE, 32'h0);
        add_item(prsm_pkg::OP_READ, 32'h0000_1000);
        add_read_typed(32'h0000_1000 + 32'd2000, 24'd0, 32'd8, 32'd8, 32'd2, 1'b1);
        // disable keeps the sum, re-enable clears it
        add_reg(prsm_pkg::REG_ENABLED, 32'hFFFF_FFFE);
        add_read_typed(32'd5, 24'd0, 32'd0, 32'd8, 32'hFFFF_FFFF, 1'b0);
        add_item(prsm_pkg::OP_PULSE, 32'h0);
        add_reg(prsm_pkg::REG_ENABLED, 32'd0);
        add_reg(prsm_pkg::REG_ENABLED, 32'hFFFF_FFFF);
        add_read_typed(32'd7, 24'd0, 32'd0, 32'd0, 32'hFFFF_FFFF, 1'b0);
    endfunction

    // ------------------------------------------------------------------
    // result side: ready pattern and checker
    // ------------------------------------------------------------------
    initial
    begin : reading_sink
        bit long_hold_done;
        int n;
        long_hold_done = 1'b0;
        out_if.ready   = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!long_hold_done && n_checked >= 60)
            begin
                // long back-pressure: the block fills and stalls its input
                long_hold_done = 1'b1;
                out_if.ready <= 1'b0;
                repeat (HOLD_CYC - 1) @(negedge clk);
            end
            else if (idle_on && $urandom_range(0, 4) == 0)
            begin
                n = $urandom_range(1, 10);
                out_if.ready <= 1'b0;
                repeat (n - 1) @(negedge clk);
            end
            else
            begin
                out_if.ready <= 1'b1;
            end
        end
    end

    task automatic check_field(input string fname, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, fname, want, got);
            n_err++;
        end
    endtask

    reading_t head;

    always @(posedge clk)
    begin
        if (rst_n && out_if.valid && out_if.ready)
        begin
            if (pending_readings.size() == 0)
            begin
                $display("%0t: reading with none expected, expected nothing, actual %0h",
                         $time, out_if.speed);
                n_err++;
            end
            else
            begin
                head = pending_readings.pop_front();
                check_field("speed", {8'd0, head.speed}, {8'd0, out_if.speed});
                check_field("pulse_count", head.pulse_count, out_if.pulse_count);
                check_field("accumulated_pulses", head.accumulated,
                            out_if.accumulated_pulses);
                check_field("ms_since_pulse", head.age_ms, out_if.ms_since_pulse);
                check_field("stopped", {31'd0, head.stopped}, {31'd0, out_if.stopped});
                n_checked++;
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        reading_t    no_want;
        logic [31:0] now;
        logic [31:0] val;
        int          counted;
        int          target;
        int          burst;
        int          sel;

        no_want        = '0;
        rst_n          = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        in_if.valid    = 1'b0;
        in_if.op       = prsm_pkg::OP_PULSE;
        in_if.now_us   = '0;
        cfg_enabled    = 1'b0;
        cfg_ppm        = prsm_pkg::PPM_RESET;
        cfg_timeout_ms = prsm_pkg::TIMEOUT_RESET;
        cfg_kph        = 1'b0;
        meter_clear();

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        build_directed();
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_REG)
            begin
                wait_idle();
                reg_write(directed_rows[i].reg_idx, directed_rows[i].value);
            end
            else
            begin
                send_item(directed_rows[i].op, directed_rows[i].now,
                          directed_rows[i].typed, directed_rows[i].want);
            end
        end

        now = $urandom;
        for (int phase = 0; phase < N_PHASES; phase++)
        begin
            wait_idle();
            idle_on = (phase == N_PHASES - 1) ? 1'b0 : ($urandom_range(0, 3) != 0);

            sel = $urandom_range(0, 7);
            if (sel <= 1)
                reg_write(prsm_pkg::REG_ENABLED, $urandom & 32'hFFFF_FFFE);
            if (sel != 0)
                reg_write(prsm_pkg::REG_ENABLED, $urandom | 32'd1);
            case ($urandom_range(0, 7))
                0:       val = 32'd1;
                1:       val = 32'h0000_FFFF;
                2:       val = 32'd0;
                3:       val = $urandom;
                default: val = $urandom_range(500, 8000);
            endcase
            reg_write(prsm_pkg::REG_PPM, val);
            case ($urandom_range(0, 5))
                0:       val = 32'd0;
                1:       val = 32'hFFFF_FFFF;
                2, 3:    val = $urandom_range(0, 3000);
                4:       val = $urandom_range(3000, 100000);
                default: val = $urandom;
            endcase
            reg_write(prsm_pkg::REG_TIMEOUT, val);
            reg_write(prsm_pkg::REG_UNITS, $urandom);

            // ignored pulses do not count, so keep disabled phases short
            target  = cfg_enabled ? PHASE_ITEMS : 15;
            counted = 0;
            while (counted < target)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    // noise: a lone item with an arbitrary timestamp
                    sel = $urandom_range(0, 1);
                    send_item(sel[0], $urandom, 1'b0, no_want);
                    if (sel[0] == prsm_pkg::OP_READ || cfg_enabled)
                        counted++;
                end
                else
                begin
                    burst = $urandom_range(0, 12);
                    repeat (burst)
                    begin
                        send_item(prsm_pkg::OP_PULSE, $urandom, 1'b0, no_want);
                        if (cfg_enabled)
                            counted++;
                    end
                    case ($urandom_range(0, 7))
                        0:       now = now;
                        1:       now = now + $urandom;
                        2:       now = now + $urandom_range(1, 1000);
                        3, 4, 5: now = now + $urandom_range(10000, 500000);
                        default: now = now + $urandom_range(500000, 5000000);
                    endcase
                    send_item(prsm_pkg::OP_READ, now, 1'b0, no_want);
                    counted++;
                end
            end
        end

        @(negedge clk);
        in_if.valid <= 1'b0;
        while (pending_readings.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);

        if (n_err == 0 && pending_readings.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin : watchdog
        #4_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/prsm_pkg.sv
rtl/core/prsm_if.sv
rtl/core/prsm_cfg.sv
rtl/core/prsm_div.sv
rtl/core/pulse_rate_speed_meter_unit.sv
sim/tb_top.sv
